/* src/ipa_pkg.sv */
`timescale 1ns / 1ps

package ipa_pkg;

   localparam int NUM_BITS    = 10;
   localparam int LEVEL_COUNT = 11;
   localparam int COUNT_BITS  = 16;

   localparam int SHIFT_BITS = 6;
   localparam int WALK_BITS  = NUM_BITS + 2;
   localparam int SEG_BITS   = NUM_BITS + 2;
   localparam int ADDR_BITS  = NUM_BITS + 3;
   localparam int LVL_BITS   = $clog2(LEVEL_COUNT + 1);
   localparam int DEPTH      = 8 << NUM_BITS;
   localparam int PMAX       = (1 << NUM_BITS) - 1;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic OP_PLACE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [1:0] CLS_ORIG_IN    = 2'd0;
   localparam logic [1:0] CLS_ORIG_AFTER = 2'd1;
   localparam logic [1:0] CLS_REPL_IN    = 2'd2;
   localparam logic [1:0] CLS_REPL_AFTER = 2'd3;

   typedef struct packed {
      logic        operation;
      logic [31:0] record_id;
      logic [31:0] start_time;
      logic [31:0] end_time;
   } req_type;

   typedef struct packed {
      logic [31:0] placed_id;
      logic [3:0]  level;
      logic [9:0]  partition_index;
      logic [1:0]  partition_class;
      logic [15:0] slot;
      logic        overflow;
      logic        cleared;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic                 rd_en;
      logic                 inc_en;
      logic                 clr_en;
   } cnt_cmd_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] value;
      logic                  full;
   } cnt_stat_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } push_type;

endpackage

/* src/interval_partition_assigner.sv */
`timescale 1ns / 1ps
// place transfer: busy while it walks L levels and makes P placements, each placement a
//   read-modify-write on the single counter port; P is at most 22 at the default size
// clear transfer: sweeps all 8192 counter entries, one entry per cycle, then the acknowledge
// reversed interval: accepted and dropped, no result
// reset: synchronous, active high; clears control state and starts the same sweep of all
//   8192 counter entries, no input transfer is taken until it ends

module interval_partition_assigner (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ipa_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ipa_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [ipa_pkg::SHIFT_BITS-1:0]  csr_wr_data
);
   import ipa_pkg::*;

   // configuration: prefix shift register
   logic [SHIFT_BITS-1:0] shift_ff;

   // result output register, parts the sequencer from the consumer
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    rsp_free;

   cnt_cmd_type  cnt_cmd;
   cnt_stat_type cnt_stat;
   push_type     push;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
      end else if (csr_wr_en) begin
         shift_ff <= csr_wr_data;
      end
   end

   // output register is free when empty or being transferred this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // sequencer walks the levels and issues counter read-modify-writes
   ipa_sequencer u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .prefix_shift (shift_ff),
      .rsp_free     (rsp_free),
      .cnt_stat     (cnt_stat),
      .cnt_cmd      (cnt_cmd),
      .push         (push)
   );

   // shared counter memory with saturating increment
   ipa_counter_unit u_cnt (
      .clock    (clock),
      .cnt_cmd  (cnt_cmd),
      .cnt_stat (cnt_stat)
   );

   // sequencer pushes only when the register is free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         rsp_data_ff <= push.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/ipa_counter_unit.sv */
`timescale 1ns / 1ps

module ipa_counter_unit (
   input  logic                  clock,
   input  ipa_pkg::cnt_cmd_type  cnt_cmd,
   output ipa_pkg::cnt_stat_type cnt_stat
);
   import ipa_pkg::*;

   logic [COUNT_BITS-1:0] mem [DEPTH];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  full;

   assign full = (rd_data_ff == CNT_MAX);

   // one address port: read, saturating write-back, or clear
   always_ff @(posedge clock) begin
      if (cnt_cmd.clr_en) begin
         mem[cnt_cmd.addr] <= '0;
      end else if (cnt_cmd.inc_en && !full) begin
         mem[cnt_cmd.addr] <= rd_data_ff + COUNT_BITS'(1);
      end
      if (cnt_cmd.rd_en) begin
         rd_data_ff <= mem[cnt_cmd.addr];
      end
   end

   assign cnt_stat.value = rd_data_ff;
   assign cnt_stat.full  = full;

endmodule

/* src/ipa_sequencer.sv */
`timescale 1ns / 1ps

module ipa_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ipa_pkg::req_type                req_data,
   input  logic [ipa_pkg::SHIFT_BITS-1:0]  prefix_shift,
   input  logic                            rsp_free,
   input  ipa_pkg::cnt_stat_type           cnt_stat,
   output ipa_pkg::cnt_cmd_type            cnt_cmd,
   output ipa_pkg::push_type               push
);
   import ipa_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_LEFT  = 8'b00000010,
      S_RIGHT = 8'b00000100,
      S_READ  = 8'b00001000,
      S_WRITE = 8'b00010000,
      S_FLUSH = 8'b00100000,
      S_CLEAR = 8'b01000000,
      S_ACK   = 8'b10000000
   } state_type;

   localparam logic signed [WALK_BITS-1:0] WALK_ONE = WALK_BITS'(1);
   localparam logic [SEG_BITS-1:0]         SEG_TOP  = SEG_BITS'(2 << NUM_BITS);
   localparam logic [ADDR_BITS-1:0]        STRIDE   = ADDR_BITS'(2 << NUM_BITS);
   localparam logic [ADDR_BITS-1:0]        CLR_LAST = ADDR_BITS'(DEPTH - 1);

   state_type                    state_ff, state_in;
   logic signed [WALK_BITS-1:0]  a_ff, a_in, b_ff, b_in;
   logic [LVL_BITS-1:0]          lvl_ff, lvl_in;
   logic [SEG_BITS-1:0]          seg_ff, seg_in;
   logic                         first_ff, first_in, lastf_ff, lastf_in;
   logic [31:0]                  id_ff, id_in;
   logic [ADDR_BITS-1:0]         addr_ff, addr_in;
   logic [NUM_BITS-1:0]          idx_ff, idx_in;
   logic [1:0]                   cls_ff, cls_in;
   logic                         from_right_ff, from_right_in;
   rsp_type                      hold_ff, hold_in;
   logic                         hold_valid_ff, hold_valid_in;
   logic [ADDR_BITS-1:0]         clr_cnt_ff, clr_cnt_in;
   logic                         ack_ff, ack_in;

   logic [31:0]                  st_sh, en_sh;
   logic [NUM_BITS-1:0]          st_pre, en_pre;
   logic [NUM_BITS-1:0]          idx_mask, p_left, p_right;
   logic [ADDR_BITS-1:0]         lvl_off;
   logic signed [WALK_BITS-1:0]  b_dec;
   logic                         walk_ok;
   logic [1:0]                   cls_l, cls_r;
   rsp_type                      new_rsp;

   // level-zero prefixes, saturated
   assign st_sh  = req_data.start_time >> prefix_shift;
   assign en_sh  = req_data.end_time >> prefix_shift;
   assign st_pre = (st_sh > 32'(PMAX)) ? NUM_BITS'(PMAX) : st_sh[NUM_BITS-1:0];
   assign en_pre = (en_sh > 32'(PMAX)) ? NUM_BITS'(PMAX) : en_sh[NUM_BITS-1:0];

   // seg holds 2 << (NUM_BITS - level)
   assign idx_mask = NUM_BITS'((seg_ff >> 1) - SEG_BITS'(1));
   assign lvl_off  = STRIDE - ADDR_BITS'(seg_ff);
   assign p_left   = a_ff[NUM_BITS-1:0] & idx_mask;
   assign p_right  = b_ff[NUM_BITS-1:0] & idx_mask;
   assign b_dec    = b_ff - WALK_ONE;

   assign walk_ok = (32'(lvl_ff) < 32'(LEVEL_COUNT)) && (32'(lvl_ff) <= 32'(NUM_BITS))
                    && (a_ff <= b_ff);

   always_comb begin
      if (first_ff) begin
         cls_l = (a_ff == b_ff && !lastf_ff) ? CLS_REPL_IN : CLS_REPL_AFTER;
      end else begin
         cls_l = (a_ff == b_ff && !lastf_ff) ? CLS_ORIG_IN : CLS_ORIG_AFTER;
      end
      if (!first_ff && b_dec < a_ff) begin
         cls_r = lastf_ff ? CLS_ORIG_AFTER : CLS_ORIG_IN;
      end else if (!lastf_ff) begin
         cls_r = CLS_REPL_IN;
      end else begin
         cls_r = CLS_REPL_AFTER;
      end
   end

   always_comb begin
      new_rsp                 = '0;
      new_rsp.placed_id       = id_ff;
      new_rsp.level           = 4'(lvl_ff);
      new_rsp.partition_index = 10'(idx_ff);
      new_rsp.partition_class = cls_ff;
      new_rsp.slot            = 16'(cnt_stat.value);
      new_rsp.overflow        = cnt_stat.full;
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      lvl_in        = lvl_ff;
      seg_in        = seg_ff;
      first_in      = first_ff;
      lastf_in      = lastf_ff;
      id_in         = id_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      cls_in        = cls_ff;
      from_right_in = from_right_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      clr_cnt_in    = clr_cnt_ff;
      ack_in        = ack_ff;
      push          = '0;
      cnt_cmd       = '0;
      cnt_cmd.addr  = addr_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               id_in = req_data.record_id;
               if (req_data.operation == OP_CLEAR) begin
                  clr_cnt_in = '0;
                  ack_in     = 1'b1;
                  state_in   = S_CLEAR;
               end else if (req_data.start_time <= req_data.end_time) begin
                  a_in     = signed'({2'b00, st_pre});
                  b_in     = signed'({2'b00, en_pre});
                  lvl_in   = '0;
                  seg_in   = SEG_TOP;
                  first_in = 1'b0;
                  lastf_in = 1'b0;
                  state_in = S_LEFT;
               end
            end
         end
         S_LEFT: begin
            if (!walk_ok) begin
               state_in = S_FLUSH;
            end else if (a_ff[0]) begin
               cls_in        = cls_l;
               first_in      = 1'b1;
               if (cls_l == CLS_REPL_IN) begin
                  lastf_in = 1'b1;
               end
               idx_in        = p_left;
               addr_in       = {cls_l, {(NUM_BITS + 1){1'b0}}} + lvl_off
                               + ADDR_BITS'(p_left);
               a_in          = a_ff + WALK_ONE;
               from_right_in = 1'b0;
               state_in      = S_READ;
            end else begin
               state_in = S_RIGHT;
            end
         end
         S_RIGHT: begin
            if (!b_ff[0]) begin
               cls_in        = cls_r;
               if (cls_r == CLS_REPL_IN) begin
                  lastf_in = 1'b1;
               end
               idx_in        = p_right;
               addr_in       = {cls_r, {(NUM_BITS + 1){1'b0}}} + lvl_off
                               + ADDR_BITS'(p_right);
               b_in          = b_dec;
               from_right_in = 1'b1;
               state_in      = S_READ;
            end else begin
               a_in     = a_ff >>> 1;
               b_in     = b_ff >>> 1;
               lvl_in   = lvl_ff + LVL_BITS'(1);
               seg_in   = seg_ff >> 1;
               state_in = S_LEFT;
            end
         end
         S_READ: begin
            cnt_cmd.rd_en = 1'b1;
            // the held result goes out next cycle, so the output must be free
            if (!hold_valid_ff || rsp_free) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cnt_cmd.inc_en = 1'b1;
            if (hold_valid_ff) begin
               push.valid = 1'b1;
               push.data  = hold_ff;
            end
            hold_in       = new_rsp;
            hold_valid_in = 1'b1;
            if (from_right_ff) begin
               a_in     = a_ff >>> 1;
               b_in     = b_ff >>> 1;
               lvl_in   = lvl_ff + LVL_BITS'(1);
               seg_in   = seg_ff >> 1;
               state_in = S_LEFT;
            end else begin
               state_in = S_RIGHT;
            end
         end
         S_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = S_IDLE;
            end else if (rsp_free) begin
               push.valid     = 1'b1;
               push.data      = hold_ff;
               push.data.last = 1'b1;
               hold_valid_in  = 1'b0;
               state_in       = S_IDLE;
            end
         end
         S_CLEAR: begin
            cnt_cmd.addr   = clr_cnt_ff;
            cnt_cmd.clr_en = 1'b1;
            clr_cnt_in     = clr_cnt_ff + ADDR_BITS'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = ack_ff ? S_ACK : S_IDLE;
            end
         end
         S_ACK: begin
            if (rsp_free) begin
               push.valid        = 1'b1;
               push.data         = '0;
               push.data.cleared = 1'b1;
               push.data.last    = 1'b1;
               ack_in            = 1'b0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         ack_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         first_ff      <= 1'b0;
         lastf_ff      <= 1'b0;
         from_right_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         ack_ff        <= ack_in;
         hold_valid_ff <= hold_valid_in;
         first_ff      <= first_in;
         lastf_ff      <= lastf_in;
         from_right_ff <= from_right_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      lvl_ff  <= lvl_in;
      seg_ff  <= seg_in;
      id_ff   <= id_in;
      addr_ff <= addr_in;
      idx_ff  <= idx_in;
      cls_ff  <= cls_in;
      hold_ff <= hold_in;
   end

endmodule

/* src/ipa_checker.sv */
`timescale 1ns / 1ps

module ipa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input ipa_pkg::req_type                req_data,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input ipa_pkg::rsp_type                rsp_data
);
   import ipa_pkg::*;

   localparam int MAX_LEVEL = (LEVEL_COUNT - 1 < NUM_BITS) ? LEVEL_COUNT - 1 : NUM_BITS;

   // clear acknowledge is a lone, empty, final result
   a_clear_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cleared |->
         rsp_data.last && rsp_data.placed_id == 32'd0 && rsp_data.slot == 16'd0
         && !rsp_data.overflow && rsp_data.level == 4'd0)
      else $error("clear acknowledge malformed");

   // placements never go above the top level
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.cleared |-> 32'(rsp_data.level) <= MAX_LEVEL)
      else $error("placement level out of range");

   // a clear transfer starts the sweep, input stalls
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.operation == OP_CLEAR |=> req_stall)
      else $error("clear did not stall input");

   // reset starts the counter sweep
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input not stalled after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind interval_partition_assigner ipa_checker u_ipa_checker (.*);
